// ===== hw/rtl/fcr_pkg.sv =====
// Shared constants, types and control bundles for the FIR convolution reverb.
// Used by the channel interfaces, the storage and MAC units and the top level.
`default_nettype none

package fcr_pkg;

  localparam int MAX_TAPS      = 64;
  localparam int SAMPLE_BITS   = 16;
  localparam int VALUE_BITS    = 16;
  localparam int TAP_IDX_BITS  = 6;
  localparam int TAPS_CFG_BITS = 7;
  localparam int WET_BITS      = 38;
  localparam int TAPS_RESET    = 64;

  localparam int ADDR_BITS  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int DEPTH      = 2 ** ADDR_BITS;
  localparam int COUNT_BITS = $clog2(MAX_TAPS + 1);
  localparam int PROD_BITS  = 2 * SAMPLE_BITS;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [WET_BITS-1:0]    wet_t;
  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic [COUNT_BITS-1:0]         count_t;

  // Writes, clears and reads requested of the history and tap memories.
  typedef struct packed {
    logic    hist_we;
    addr_t   hist_waddr;
    sample_t hist_wdata;
    logic    hist_clear;
    logic    tap_we;
    addr_t   tap_waddr;
    sample_t tap_wdata;
    logic    rd_en;
    addr_t   hist_raddr;
    addr_t   tap_raddr;
  } store_cmd_t;

  // Registered read data, valid in the cycle after the read was issued.
  typedef struct packed {
    logic    valid;
    sample_t hist;
    sample_t tap;
  } store_rsp_t;

endpackage : fcr_pkg

`default_nettype wire

// ===== hw/rtl/fcr_if.sv =====
// Valid/ready channel interfaces: dry input, wet output and tap-count configuration.
// Depends on fcr_pkg for field widths.
`default_nettype none

interface fcr_in_if import fcr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [TAP_IDX_BITS-1:0]       tap_index;
  logic signed [VALUE_BITS-1:0]  value;
  logic                          final_sample;

  modport source (output valid, op, tap_index, value, final_sample, input ready);
  modport sink   (input valid, op, tap_index, value, final_sample, output ready);
endinterface : fcr_in_if

interface fcr_out_if import fcr_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [WET_BITS-1:0]  wet_sample;
  logic                        last_of_signal;

  modport source (output valid, wet_sample, last_of_signal, input ready);
  modport sink   (input valid, wet_sample, last_of_signal, output ready);
endinterface : fcr_out_if

interface fcr_cfg_if import fcr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [TAPS_CFG_BITS-1:0]  taps_in_use;

  modport source (output valid, taps_in_use, input ready);
  modport sink   (input valid, taps_in_use, output ready);
endinterface : fcr_cfg_if

`default_nettype wire

// ===== hw/rtl/fcr_store.sv =====
// Sample history and impulse tap memories with registered reads.
// Depends on fcr_pkg for the command and response bundles.
`default_nettype none

module fcr_store
  import fcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  store_cmd_t cmd,
  output store_rsp_t rsp
);

  sample_t    hist_mem [DEPTH];
  sample_t    tap_mem  [DEPTH];
  logic [DEPTH-1:0] hist_vld;
  logic [DEPTH-1:0] tap_vld;

  sample_t hist_q;
  sample_t tap_q;
  logic    hist_v_q;
  logic    tap_v_q;
  logic    rd_v;

  always_ff @(posedge clk) begin
    if (cmd.hist_we) begin
      hist_mem[cmd.hist_waddr] <= cmd.hist_wdata;
    end
    if (cmd.tap_we) begin
      tap_mem[cmd.tap_waddr] <= cmd.tap_wdata;
    end
    hist_q   <= hist_mem[cmd.hist_raddr];
    tap_q    <= tap_mem[cmd.tap_raddr];
    hist_v_q <= hist_vld[cmd.hist_raddr];
    tap_v_q  <= tap_vld[cmd.tap_raddr];
  end

  // Entries never written since reset (or since the history was flushed) read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
      tap_vld  <= '0;
      rd_v     <= 1'b0;
    end else begin
      if (cmd.hist_clear) begin
        hist_vld <= '0;
      end
      if (cmd.hist_we) begin
        hist_vld[cmd.hist_waddr] <= 1'b1;
      end
      if (cmd.tap_we) begin
        tap_vld[cmd.tap_waddr] <= 1'b1;
      end
      rd_v <= cmd.rd_en;
    end
  end

  assign rsp.valid = rd_v;
  assign rsp.hist  = hist_v_q ? hist_q : '0;
  assign rsp.tap   = tap_v_q ? tap_q : '0;

endmodule : fcr_store

`default_nettype wire

// ===== hw/rtl/fcr_mac.sv =====
// Registered multiplier followed by a wide accumulator.
// Depends on fcr_pkg for sample, product and accumulator types.
`default_nettype none

module fcr_mac
  import fcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       clear,
  input  store_rsp_t rsp,
  output logic       busy,
  output wet_t       acc
);

  prod_t prod;
  logic  prod_v;

  always_ff @(posedge clk) begin
    prod <= rsp.hist * rsp.tap;
    if (clear) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + wet_t'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= rsp.valid;
    end
  end

  assign busy = prod_v;

endmodule : fcr_mac

`default_nettype wire

// ===== hw/rtl/fir_convolution_reverb_unit.sv =====
// Top level of the FIR convolution reverb: sequencer, configuration register, output register.
// Depends on fcr_pkg, the fcr channel interfaces, fcr_store and fcr_mac.
`default_nettype none

// Direct-form FIR convolution of a dry stream with a loaded impulse response of M taps
// (M = taps_in_use, taken as 1 when written as 0 and as 64 above 64). A load transfer
// (op = 0) writes one Q1.15 tap. A sample transfer (op = 1) enters the history line
// and yields one 38-bit Q8.30 output, the exact sum of M products; the sample flagged
// final_sample then yields M-1 tail outputs with zeros shifted in, the last of them
// carrying last_of_signal, after which the history is flushed. The history sits in a
// 64-entry circular memory and the taps in a second memory; one tap is read from each
// per cycle and fed through a single registered multiplier into the accumulator, and
// no new input transfer is accepted until the previous sample and all of its tail
// outputs have reached the output register. The output register lets the next input
// be taken while an earlier result still waits to be transferred. Both stores read as
// zero after reset; no clearing pass is needed.
// Configuration should only be written while the block is idle.

module fir_convolution_reverb_unit
  import fcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  fcr_cfg_if.sink    cfg,
  fcr_in_if.sink     dry_in,
  fcr_out_if.source  wet_out
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t state;

  logic [TAPS_CFG_BITS-1:0] taps_cfg;
  count_t  active_taps;
  count_t  taps;       // tap count latched for the signal in progress
  count_t  tap_cnt;    // tap being read in the current pass
  count_t  tail_left;  // tail outputs still owed after the current one
  logic    fin;
  addr_t   wp;         // history entry holding the newest sample

  logic    out_valid;
  wet_t    out_wet;
  logic    out_last;

  store_cmd_t cmd;
  store_rsp_t rsp;
  logic       mac_clear;
  logic       mac_busy;
  wet_t       acc;

  logic    in_xfer;
  logic    is_sample;
  logic    slot_free;
  logic    pass_done;
  sample_t in_sample;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      taps_cfg <= TAPS_CFG_BITS'(TAPS_RESET);
    end else if (cfg.valid && cfg.ready) begin
      taps_cfg <= cfg.taps_in_use;
    end
  end

  // A zero count means one tap; anything beyond the store depth saturates.
  always_comb begin
    if (taps_cfg == '0) begin
      active_taps = count_t'(1);
    end else if (taps_cfg > TAPS_CFG_BITS'(MAX_TAPS)) begin
      active_taps = count_t'(MAX_TAPS);
    end else begin
      active_taps = count_t'(taps_cfg);
    end
  end

  assign dry_in.ready = (state == S_IDLE);
  assign in_xfer      = dry_in.valid && dry_in.ready;
  assign is_sample    = (dry_in.op == OP_SAMPLE);
  assign in_sample    = sample_t'(dry_in.value[SAMPLE_BITS-1:0]);

  // The pass is finished once the last product has reached the accumulator; the
  // result is handed over only when the output register is free or being emptied.
  assign slot_free = !out_valid || wet_out.ready;
  assign pass_done = (state == S_DRAIN) && !rsp.valid && !mac_busy && slot_free;

  always_comb begin
    cmd       = '0;
    mac_clear = 1'b0;
    if (in_xfer) begin
      if (is_sample) begin
        cmd.hist_we    = 1'b1;
        cmd.hist_waddr = wp + addr_t'(1);
        cmd.hist_wdata = in_sample;
        mac_clear      = 1'b1;
      end else if (int'(dry_in.tap_index) < MAX_TAPS) begin
        cmd.tap_we    = 1'b1;
        cmd.tap_waddr = addr_t'(dry_in.tap_index);
        cmd.tap_wdata = in_sample;
      end
    end
    if (state == S_RUN) begin
      // Tap j pairs with the sample j entries behind the newest one.
      cmd.rd_en      = 1'b1;
      cmd.hist_raddr = wp - tap_cnt[ADDR_BITS-1:0];
      cmd.tap_raddr  = tap_cnt[ADDR_BITS-1:0];
    end
    if (pass_done) begin
      if (tail_left != '0) begin
        cmd.hist_we    = 1'b1;
        cmd.hist_waddr = wp + addr_t'(1);
        cmd.hist_wdata = '0;
        mac_clear      = 1'b1;
      end else begin
        cmd.hist_clear = fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      tap_cnt   <= '0;
      taps      <= count_t'(1);
      tail_left <= '0;
      fin       <= 1'b0;
      out_valid <= 1'b0;
      out_wet   <= '0;
      out_last  <= 1'b0;
    end else begin
      if (wet_out.ready && !pass_done) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer && is_sample) begin
            wp        <= wp + addr_t'(1);
            tap_cnt   <= '0;
            taps      <= active_taps;
            fin       <= dry_in.final_sample;
            tail_left <= dry_in.final_sample ? active_taps - count_t'(1) : '0;
            state     <= S_RUN;
          end
        end
        S_RUN: begin
          tap_cnt <= tap_cnt + count_t'(1);
          if (tap_cnt == taps - count_t'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (pass_done) begin
            out_valid <= 1'b1;
            out_wet   <= acc;
            out_last  <= fin && (tail_left == '0);
            if (tail_left != '0) begin
              wp        <= wp + addr_t'(1);
              tap_cnt   <= '0;
              tail_left <= tail_left - count_t'(1);
              state     <= S_RUN;
            end else begin
              fin   <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign wet_out.valid          = out_valid;
  assign wet_out.wet_sample     = out_wet;
  assign wet_out.last_of_signal = out_last;

  fcr_store u_store (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  fcr_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .clear (mac_clear),
    .rsp   (rsp),
    .busy  (mac_busy),
    .acc   (acc)
  );

endmodule : fir_convolution_reverb_unit

`default_nettype wire

// ===== test/fcr_reverb_checker.sv =====
// Checker for the FIR convolution reverb: watches the configuration, dry and wet channels,
// predicts every wet sample and compares it with what the block transfers.
// Depends on fcr_pkg for widths, types and the operation codes.
`default_nettype none

module fcr_reverb_checker
  import fcr_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [TAPS_CFG_BITS-1:0]     cfg_taps,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_op,
  input  logic [TAP_IDX_BITS-1:0]      in_tap_index,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic                         in_final,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [WET_BITS-1:0]   out_wet,
  input  logic                         out_last,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    wet_t wet;
    logic last;
  } wet_item_t;

  sample_t                  history [MAX_TAPS];
  sample_t                  ir_taps [MAX_TAPS];
  logic [TAPS_CFG_BITS-1:0] taps_reg;
  wet_item_t                wet_queue [$];
  int                       errors = 0;

  function automatic longint tap_sum(int n_taps);
    longint acc;
    acc = 0;
    for (int j = 0; j < n_taps; j++) begin
      acc += longint'(history[j]) * longint'(ir_taps[j]);
    end
    return acc;
  endfunction

  function automatic void shift_in(sample_t s);
    for (int j = MAX_TAPS - 1; j > 0; j--) begin
      history[j] = history[j-1];
    end
    history[0] = s;
  endfunction

  function automatic void queue_wet(longint acc, logic last);
    wet_item_t item;
    item.wet  = wet_t'(acc);
    item.last = last;
    wet_queue.push_back(item);
  endfunction

  // Taps count 0 behaves as one tap, anything above the store depth as the full store.
  task automatic take_dry_item(logic op, logic [TAP_IDX_BITS-1:0] idx, sample_t val,
                               logic fin);
    int n_taps;
    n_taps = (taps_reg == 0) ? 1 : (taps_reg > MAX_TAPS) ? MAX_TAPS : int'(taps_reg);
    if (op == OP_LOAD) begin
      ir_taps[idx] = val;
    end else begin
      shift_in(val);
      queue_wet(tap_sum(n_taps), fin && (n_taps == 1));
      if (fin) begin
        for (int t = 1; t < n_taps; t++) begin
          shift_in('0);
          queue_wet(tap_sum(n_taps), t == n_taps - 1);
        end
        for (int j = 0; j < MAX_TAPS; j++) begin
          history[j] = '0;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    wet_item_t want;
    if (rst) begin
      for (int j = 0; j < MAX_TAPS; j++) begin
        history[j] = '0;
        ir_taps[j] = '0;
      end
      taps_reg = TAPS_CFG_BITS'(TAPS_RESET);
      wet_queue.delete();
    end else begin
      // Results are retired before new predictions are queued, so a spurious
      // result is never matched against an item taken at the same edge.
      if (out_valid && out_ready) begin
        if (wet_queue.size() == 0) begin
          $error("unexpected wet sample %0d, last_of_signal %0b", out_wet, out_last);
          errors++;
        end else begin
          want = wet_queue.pop_front();
          if (out_wet !== want.wet) begin
            $error("wet_sample: expected %0d, actual %0d", $signed(want.wet), out_wet);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last_of_signal: expected %0b, actual %0b", want.last, out_last);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        taps_reg = cfg_taps;
      end
      if (in_valid && in_ready) begin
        take_dry_item(in_op, in_tap_index, in_value, in_final);
      end
    end
    pending    <= wet_queue.size();
    fail_count <= errors;
  end

endmodule : fcr_reverb_checker

`default_nettype wire

// ===== test/tb_top.sv =====
// Top of the FIR convolution reverb testbench: clock, reset, stimulus and verdict.
// Depends on fcr_pkg, the fcr channel interfaces, the block itself and fcr_reverb_checker.
`default_nettype none

module tb_top;
  import fcr_pkg::*;

  // Twice the store depth is ample for any item still in flight once the last expected
  // result has arrived.
  localparam int SETTLE_CYCLES = 2 * MAX_TAPS;
  localparam int RANDOM_ITEMS  = 300;
  // The limit lies well above the slowest run with this stimulus (every tail at full
  // length, every result waiting out the longest stall).
  localparam int CYCLE_LIMIT   = 5_000_000;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   items_sent = 0;
  // While set, neither side inserts idle cycles, which gives stretches of full throughput.
  bit   calm = 1'b0;

  fcr_cfg_if cfg_ch ();
  fcr_in_if  dry_ch ();
  fcr_out_if wet_ch ();

  fir_convolution_reverb_unit dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .dry_in  (dry_ch),
    .wet_out (wet_ch)
  );

  fcr_reverb_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_ch.valid),
    .cfg_ready    (cfg_ch.ready),
    .cfg_taps     (cfg_ch.taps_in_use),
    .in_valid     (dry_ch.valid),
    .in_ready     (dry_ch.ready),
    .in_op        (dry_ch.op),
    .in_tap_index (dry_ch.tap_index),
    .in_value     (dry_ch.value),
    .in_final     (dry_ch.final_sample),
    .out_valid    (wet_ch.valid),
    .out_ready    (wet_ch.ready),
    .out_wet      (wet_ch.wet_sample),
    .out_last     (wet_ch.last_of_signal),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 14));
  endfunction

  // Values lean towards the two extremes of the Q1.15 range, where the products are largest.
  function automatic sample_t draw_value();
    case ($urandom_range(0, 7))
      0:       return sample_t'(16'sh8000);
      1:       return sample_t'(16'sh7fff);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic int active_taps(logic [TAPS_CFG_BITS-1:0] v);
    return (v == 0) ? 1 : (v > MAX_TAPS) ? MAX_TAPS : int'(v);
  endfunction

  // The wet side draws a fresh stall before every result. With no stall the ready line
  // simply stays high, so it never sees two assignments in one time step.
  initial begin
    int stall;
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        wet_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      wet_ch.ready <= 1'b1;
      @(posedge clk);
      while (!wet_ch.valid) @(posedge clk);
    end
  end

  // One dry transfer. Valid is only lowered when a gap is drawn, so back-to-back items keep
  // it high across the transfer edge and the payload changes beneath it.
  task automatic push_item(op_t op, logic [TAP_IDX_BITS-1:0] idx, sample_t val, logic fin);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      dry_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    dry_ch.valid        <= 1'b1;
    dry_ch.op           <= op;
    dry_ch.tap_index    <= idx;
    dry_ch.value        <= val;
    dry_ch.final_sample <= fin;
    @(posedge clk);
    while (!dry_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Brings the block to rest: valid is dropped at the edge of the last transfer, then we
  // wait for every predicted result and let a possible trailing load finish.
  task automatic settle();
    dry_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_taps(logic [TAPS_CFG_BITS-1:0] v);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.taps_in_use <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [TAPS_CFG_BITS-1:0] taps_cfg;
    int                       eff;
    int                       len;
    logic                     fin;
    logic [TAP_IDX_BITS-1:0]  idx;

    rst                 <= 1'b1;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.taps_in_use  <= '0;
    dry_ch.valid        <= 1'b0;
    dry_ch.op           <= OP_LOAD;
    dry_ch.tap_index    <= '0;
    dry_ch.value        <= '0;
    dry_ch.final_sample <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The tap count is still at its reset value of the full store, so the
    // first signal runs the longest tail with both extremes sitting in the end taps. A load
    // carries the final flag to show that it is ignored there.
    push_item(OP_LOAD, 6'd0, 16'sh7fff, 1'b1);
    push_item(OP_LOAD, 6'd63, 16'sh8000, 1'b0);
    push_item(OP_LOAD, 6'd1, 16'sh8000, 1'b0);
    push_item(OP_SAMPLE, 6'd63, 16'sh8000, 1'b0);
    push_item(OP_SAMPLE, 6'd0, 16'sh7fff, 1'b0);
    push_item(OP_SAMPLE, 6'd5, 16'sh0001, 1'b1);

    // A single tap has no tail: the final sample's own output closes the signal.
    settle();
    write_taps(7'd1);
    push_item(OP_SAMPLE, 6'h2a, 16'sh8000, 1'b1);
    push_item(OP_SAMPLE, 6'h15, 16'sh7fff, 1'b0);
    push_item(OP_SAMPLE, 6'd0, 16'shffff, 1'b1);

    // A count of zero behaves as one tap.
    settle();
    write_taps(7'd0);
    push_item(OP_SAMPLE, 6'd0, 16'sh8000, 1'b1);

    // A count beyond the store saturates to the full store.
    settle();
    write_taps(7'd127);
    push_item(OP_SAMPLE, 6'd0, 16'sh7fff, 1'b1);

    // Two taps of the most negative value against two such samples: the largest product.
    settle();
    write_taps(7'd2);
    push_item(OP_LOAD, 6'd0, 16'sh8000, 1'b0);
    push_item(OP_LOAD, 6'd1, 16'sh8000, 1'b0);
    push_item(OP_SAMPLE, 6'd0, 16'sh8000, 1'b0);
    push_item(OP_SAMPLE, 6'd0, 16'sh8000, 1'b1);

    // Random part, in phases. Each phase sets a tap count, mostly short so that tails stay
    // cheap, refreshes some taps and then sends whole signals ending in a final sample. A
    // few signals lose their final flag, so the history runs on into the next phase, and
    // some phases add a burst of entirely random items.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 15))
        0:       taps_cfg = 7'd64;
        1:       taps_cfg = TAPS_CFG_BITS'($urandom_range(65, 127));
        2:       taps_cfg = 7'd0;
        default: taps_cfg = TAPS_CFG_BITS'($urandom_range(1, 10));
      endcase
      write_taps(taps_cfg);
      eff  = active_taps(taps_cfg);
      calm = ($urandom_range(0, 3) == 0);

      repeat ($urandom_range(0, ((eff < 10) ? eff : 10) + 2)) begin
        if ($urandom_range(0, 3) == 0) begin
          idx = TAP_IDX_BITS'($urandom());
        end else begin
          idx = TAP_IDX_BITS'($urandom_range(0, eff - 1));
        end
        push_item(OP_LOAD, idx, draw_value(), 1'($urandom()));
      end

      repeat ($urandom_range(1, 3)) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          fin = (k == len - 1) && ($urandom_range(0, 5) != 0);
          push_item(OP_SAMPLE, TAP_IDX_BITS'($urandom()), draw_value(), fin);
        end
      end

      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          push_item(op_t'($urandom_range(0, 1)), TAP_IDX_BITS'($urandom()), draw_value(),
                    1'($urandom()));
        end
      end
    end

    calm = 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule : tb_top

`default_nettype wire
